// ----- rtl/core/fsac_pkg.sv -----
// Package: shared types, opcodes and constants for the stack ALU core.
package fsac_pkg;
   localparam int CELL_BITS = 16;
   localparam int DATA_DEPTH = 32;
   localparam int RETURN_DEPTH = 32;
   localparam int DPTR_BITS = $clog2(DATA_DEPTH + 1);
   localparam int RPTR_BITS = $clog2(RETURN_DEPTH + 1);
   localparam int DIDX_BITS = $clog2(DATA_DEPTH);
   localparam int RIDX_BITS = $clog2(RETURN_DEPTH);
   localparam int CNT_BITS = 6;
   localparam int LIT_BITS = 16;
   localparam int OP_BITS = 5;
   localparam int ERR_BITS = 3;
   localparam int DIV_STEPS = 2 * CELL_BITS;
   localparam int STEP_BITS = $clog2(DIV_STEPS + 1);

   typedef logic [CELL_BITS-1:0] cell_type;
   typedef logic [2*CELL_BITS-1:0] dcell_type;

   typedef enum logic [OP_BITS-1:0] {
      OP_LIT = 5'd0, OP_DROP = 5'd1, OP_DUP = 5'd2, OP_SWAP = 5'd3,
      OP_PICK = 5'd4, OP_ADD = 5'd5, OP_SUB = 5'd6, OP_MUL = 5'd7,
      OP_DIV = 5'd8, OP_MOD = 5'd9, OP_TOR = 5'd10, OP_FROMR = 5'd11,
      OP_EQ = 5'd12, OP_LT = 5'd13, OP_AND = 5'd14, OP_OR = 5'd15,
      OP_XOR = 5'd16, OP_SHL = 5'd17, OP_SHR = 5'd18, OP_DEPTH = 5'd19,
      OP_RDEPTH = 5'd20, OP_UMA = 5'd21, OP_ULT = 5'd22, OP_UMMOD = 5'd23
   } op_type;

   typedef enum logic [ERR_BITS-1:0] {
      ERR_OK = 3'd0, ERR_UNDER = 3'd1, ERR_OVER = 3'd2,
      ERR_DIVZ = 3'd3, ERR_OPCODE = 3'd4
   } err_type;

   // classified operation handed from front to back
   typedef struct packed {
      logic     known;
      op_type   op;
      cell_type lit;
      logic [2:0] reads;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_EXEC, ST_MUL,
      ST_DIV, ST_FIX, ST_WB0, ST_WB1, ST_OUT0, ST_OUT1, ST_DONE
   } state_type;

   function automatic logic [2:0] reads_needed(input logic [OP_BITS-1:0] op);
      case (op)
         OP_LIT, OP_FROMR, OP_DEPTH, OP_RDEPTH: reads_needed = 3'd0;
         OP_DROP, OP_DUP, OP_PICK, OP_TOR: reads_needed = 3'd1;
         OP_DIV, OP_MOD, OP_UMMOD: reads_needed = 3'd3;
         OP_UMA: reads_needed = 3'd4;
         default: reads_needed = 3'd2;
      endcase
   endfunction
endpackage

// ----- rtl/core/fsac_front.sv -----
// Front end: accepts requests, classifies them and queues commands.
module fsac_front import fsac_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [23:0] req_tdata, // operation[4:0], literal[20:5], zero pad
   output logic cmd_valid,
   input  logic cmd_ready,
   output cmd_type cmd
);
   localparam int QD = 2;
   cmd_type q_ff [QD];
   logic [1:0] cnt_ff, cnt_in;
   logic wr_ff, wr_in, rd_ff, rd_in;
   cmd_type c;
   logic push, pop;

   // classify
   always_comb begin
      c.op = op_type'(req_tdata[OP_BITS-1:0]);
      c.known = req_tdata[OP_BITS-1:0] <= 5'd23;
      c.lit = cell_type'($signed(req_tdata[OP_BITS +: LIT_BITS]));
      c.reads = reads_needed(req_tdata[OP_BITS-1:0]);
   end

   assign req_tready = cnt_ff != 2'(QD);
   assign cmd_valid = cnt_ff != 2'd0;
   assign cmd = q_ff[rd_ff];
   assign push = req_tvalid && req_tready;
   assign pop = cmd_valid && cmd_ready;

   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
      wr_in = push ? ~wr_ff : wr_ff;
      rd_in = pop ? ~rd_ff : rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
      if (push) q_ff[wr_ff] <= c;
   end

   // queue never overfills or underflows
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'(QD))
      else $error("queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("push lost");
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !cmd_valid)
      else $error("valid from empty queue");
endmodule

// ----- rtl/core/fsac_back.sv -----
// Back end: stack memories, sequencer, multiplier and iterative divider.
module fsac_back import fsac_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic cmd_valid,
   output logic cmd_ready,
   input  cmd_type cmd,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [55:0] rsp_tdata
);
   cell_type dmem [DATA_DEPTH];
   cell_type rmem [RETURN_DEPTH];
   state_type st_ff, st_in;
   cmd_type cmd_ff;
   logic [DPTR_BITS-1:0] dp_ff, dp_in;
   logic [RPTR_BITS-1:0] rp_ff, rp_in;
   cell_type a_ff, b_ff, c_ff, rdq_ff, rrd_ff;
   cell_type w0_ff, w0_in, w1_ff, w1_in;
   logic [DPTR_BITS-1:0] wa0_ff, wa0_in, wa1_ff, wa1_in;
   logic we0_ff, we0_in, we1_ff, we1_in;
   err_type err_ff, err_in;
   dcell_type prod_ff, num_ff, num_in, quo_ff, quo_in;
   dcell_type rem_ff, rem_in;
   cell_type den_ff, den_in;
   logic qneg_ff, qneg_in, rneg_ff, rneg_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [DPTR_BITS-1:0] raddr;
   logic rdo;
   cell_type top_ff, sec_ff, top_in, sec_in;
   logic vld_ff, vld_in;
   logic pick_sel_ff, pick_sel_in;
   logic rpush_ff, rpush_in, rpop_ff, rpop_in;
   dcell_type dsub;

   assign cmd_ready = st_ff == ST_IDLE && !vld_ff;
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata = {9'd0, err_ff, CNT_BITS'(rp_ff), CNT_BITS'(dp_ff),
                       sec_ff, top_ff};

   // read address selection for the data stack
   // second is read in OUT0, top in OUT1 after the top write has landed
   always_comb begin
      raddr = '0;
      case (st_ff)
         ST_RD0: raddr = dp_ff - DPTR_BITS'(1);
         ST_RD1: raddr = dp_ff - DPTR_BITS'(2);
         ST_RD2: raddr = pick_sel_ff ? dp_ff - DPTR_BITS'(2) - DPTR_BITS'(a_ff)
                                     : dp_ff - DPTR_BITS'(3);
         ST_RD3: raddr = dp_ff - DPTR_BITS'(4);
         ST_OUT0: raddr = dp_ff - DPTR_BITS'(2);
         ST_OUT1: raddr = dp_ff - DPTR_BITS'(1);
         default: raddr = '0;
      endcase
   end

   // divider step: restoring, one bit per cycle
   assign dsub = {rem_ff[2*CELL_BITS-2:0], num_ff[2*CELL_BITS-1]} -
                 dcell_type'(den_ff);

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (cmd_valid && cmd_ready) st_in = ST_RD0;
         ST_RD0: st_in = ST_RD1;
         ST_RD1: st_in = ST_RD2;
         ST_RD2: st_in = ST_RD3;
         ST_RD3: st_in = ST_EXEC;
         ST_EXEC: begin
            if (err_in != ERR_OK) st_in = ST_OUT0;
            else if (cmd_ff.op == OP_MUL || cmd_ff.op == OP_UMA) st_in = ST_MUL;
            else if (cmd_ff.op == OP_DIV || cmd_ff.op == OP_MOD ||
                     cmd_ff.op == OP_UMMOD) st_in = ST_DIV;
            else st_in = ST_WB0;
         end
         ST_MUL: st_in = ST_WB0;
         ST_DIV: if (step_ff == STEP_BITS'(1)) st_in = ST_FIX;
         ST_FIX: st_in = ST_WB0;
         ST_WB0: st_in = ST_WB1;
         ST_WB1: st_in = ST_OUT0;
         ST_OUT0: st_in = ST_OUT1;
         ST_OUT1: st_in = ST_DONE;
         ST_DONE: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      dcell_type dd, dv;
      logic [DPTR_BITS:0] need;
      dp_in = dp_ff; rp_in = rp_ff; err_in = err_ff;
      w0_in = w0_ff; w1_in = w1_ff; wa0_in = wa0_ff; wa1_in = wa1_ff;
      we0_in = we0_ff; we1_in = we1_ff;
      num_in = num_ff; quo_in = quo_ff; rem_in = rem_ff; den_in = den_ff;
      qneg_in = qneg_ff; rneg_in = rneg_ff; step_in = step_ff;
      top_in = top_ff; sec_in = sec_ff; vld_in = vld_ff;
      pick_sel_in = pick_sel_ff; rpush_in = 1'b0; rpop_in = 1'b0;
      need = {1'b0, DPTR_BITS'(cmd_ff.reads)};
      dd = {b_ff, c_ff};
      dv = '0;
      if (vld_ff && rsp_tready) vld_in = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            pick_sel_in = 1'b0;
            we0_in = 1'b0; we1_in = 1'b0;
         end
         ST_RD1: pick_sel_in = cmd_ff.op == OP_PICK;
         ST_EXEC: begin
            err_in = ERR_OK;
            if (!cmd_ff.known) err_in = ERR_OPCODE;
            else if ({1'b0, dp_ff} < need) err_in = ERR_UNDER;
            else if (cmd_ff.op == OP_PICK &&
                     {{(CELL_BITS+1){1'b0}}, dp_ff} <
                     {{(DPTR_BITS+1){1'b0}}, a_ff} + (CELL_BITS+DPTR_BITS+1)'(2))
               err_in = ERR_UNDER;
            else if (cmd_ff.op == OP_FROMR && rp_ff == '0) err_in = ERR_UNDER;
            else if ((cmd_ff.op == OP_DIV || cmd_ff.op == OP_MOD ||
                      cmd_ff.op == OP_UMMOD) && a_ff == '0) err_in = ERR_DIVZ;
            else if ((cmd_ff.op == OP_LIT || cmd_ff.op == OP_DUP ||
                      cmd_ff.op == OP_FROMR || cmd_ff.op == OP_DEPTH ||
                      cmd_ff.op == OP_RDEPTH) && dp_ff >= DPTR_BITS'(DATA_DEPTH))
               err_in = ERR_OVER;
            else if (cmd_ff.op == OP_TOR && rp_ff >= RPTR_BITS'(RETURN_DEPTH))
               err_in = ERR_OVER;
            // divider setup
            if (cmd_ff.op == OP_UMMOD) begin
               qneg_in = 1'b0; rneg_in = 1'b0;
               num_in = dd; den_in = a_ff;
            end else begin
               rneg_in = b_ff[CELL_BITS-1];
               qneg_in = b_ff[CELL_BITS-1] ^ a_ff[CELL_BITS-1];
               num_in = b_ff[CELL_BITS-1] ? -dd : dd;
               den_in = a_ff[CELL_BITS-1] ? -a_ff : a_ff;
            end
            rem_in = '0; quo_in = '0;
            step_in = STEP_BITS'(DIV_STEPS);
            // results computed directly in EXEC
            wa0_in = dp_ff - DPTR_BITS'(1);
            wa1_in = dp_ff - DPTR_BITS'(2);
            case (cmd_ff.op)
               OP_LIT: begin w0_in = cmd_ff.lit; wa0_in = dp_ff; end
               OP_DUP: begin w0_in = a_ff; wa0_in = dp_ff; end
               OP_SWAP: begin w0_in = b_ff; w1_in = a_ff; end
               OP_PICK: w0_in = c_ff;
               OP_ADD: w1_in = b_ff + a_ff;
               OP_SUB: w1_in = b_ff - a_ff;
               OP_EQ: w1_in = (b_ff == a_ff) ? '1 : '0;
               OP_LT: w1_in = ($signed(b_ff) < $signed(a_ff)) ? '1 : '0;
               OP_ULT: w1_in = (b_ff < a_ff) ? '1 : '0;
               OP_AND: w1_in = b_ff & a_ff;
               OP_OR: w1_in = b_ff | a_ff;
               OP_XOR: w1_in = b_ff ^ a_ff;
               OP_SHL: w1_in = (a_ff >= cell_type'(CELL_BITS)) ? '0 : b_ff << a_ff;
               OP_SHR: w1_in = (a_ff >= cell_type'(CELL_BITS)) ? '0 : b_ff >> a_ff;
               OP_DEPTH: begin w0_in = cell_type'(dp_ff); wa0_in = dp_ff; end
               OP_RDEPTH: begin w0_in = cell_type'(rp_ff); wa0_in = dp_ff; end
               OP_FROMR: begin w0_in = rrd_ff; wa0_in = dp_ff; end
               default: ;
            endcase
         end
         ST_MUL: begin
            if (cmd_ff.op == OP_MUL) begin
               w1_in = prod_ff[CELL_BITS-1:0];
               w0_in = prod_ff[2*CELL_BITS-1:CELL_BITS];
            end else begin
               dv = prod_ff + dcell_type'(a_ff);
               wa1_in = dp_ff - DPTR_BITS'(4);
               wa0_in = dp_ff - DPTR_BITS'(3);
               w1_in = dv[CELL_BITS-1:0];
               w0_in = dv[2*CELL_BITS-1:CELL_BITS];
            end
         end
         ST_DIV: begin
            if (!dsub[2*CELL_BITS-1] ||
                rem_ff[2*CELL_BITS-1]) begin
               rem_in = dsub;
               quo_in = {quo_ff[2*CELL_BITS-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[2*CELL_BITS-2:0], num_ff[2*CELL_BITS-1]};
               quo_in = {quo_ff[2*CELL_BITS-2:0], 1'b0};
            end
            num_in = {num_ff[2*CELL_BITS-2:0], 1'b0};
            step_in = step_ff - STEP_BITS'(1);
         end
         ST_FIX: begin
            if (cmd_ff.op == OP_UMMOD) begin
               wa1_in = dp_ff - DPTR_BITS'(3);
               wa0_in = dp_ff - DPTR_BITS'(2);
               w1_in = rem_ff[CELL_BITS-1:0];
               w0_in = quo_ff[CELL_BITS-1:0];
            end else begin
               wa1_in = dp_ff - DPTR_BITS'(3);
               w1_in = (cmd_ff.op == OP_DIV)
                  ? (qneg_ff ? -quo_ff[CELL_BITS-1:0] : quo_ff[CELL_BITS-1:0])
                  : (rneg_ff ? -rem_ff[CELL_BITS-1:0] : rem_ff[CELL_BITS-1:0]);
               w0_in = w1_in;
               wa0_in = wa1_in;
            end
         end
         ST_WB0: begin
            // commit writes and pointers
            case (cmd_ff.op)
               OP_LIT, OP_DUP, OP_DEPTH, OP_RDEPTH: begin
                  we0_in = 1'b1; dp_in = dp_ff + DPTR_BITS'(1);
               end
               OP_FROMR: begin
                  we0_in = 1'b1; dp_in = dp_ff + DPTR_BITS'(1);
                  rp_in = rp_ff - RPTR_BITS'(1); rpop_in = 1'b1;
               end
               OP_DROP: dp_in = dp_ff - DPTR_BITS'(1);
               OP_TOR: begin
                  dp_in = dp_ff - DPTR_BITS'(1);
                  rp_in = rp_ff + RPTR_BITS'(1); rpush_in = 1'b1;
               end
               OP_SWAP, OP_MUL, OP_UMMOD: begin
                  we0_in = 1'b1; we1_in = 1'b1;
                  if (cmd_ff.op == OP_UMMOD) dp_in = dp_ff - DPTR_BITS'(1);
               end
               OP_UMA: begin
                  we0_in = 1'b1; we1_in = 1'b1; dp_in = dp_ff - DPTR_BITS'(2);
               end
               OP_PICK: we0_in = 1'b1;
               OP_DIV, OP_MOD: begin
                  we1_in = 1'b1; dp_in = dp_ff - DPTR_BITS'(2);
               end
               default: begin
                  we1_in = 1'b1; dp_in = dp_ff - DPTR_BITS'(1);
               end
            endcase
         end
         ST_OUT1: sec_in = (dp_ff >= DPTR_BITS'(2)) ? rdq_ff : '0;
         ST_DONE: begin
            top_in = (dp_ff >= DPTR_BITS'(1)) ? rdq_ff : '0;
            vld_in = 1'b1;
         end
         default: ;
      endcase
   end

   assign rdo = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         dp_ff <= '0;
         rp_ff <= '0;
         vld_ff <= 1'b0;
         err_ff <= ERR_OK;
      end else begin
         st_ff <= st_in;
         dp_ff <= dp_in;
         rp_ff <= rp_in;
         vld_ff <= vld_in;
         err_ff <= err_in;
      end
      if (st_ff == ST_IDLE && cmd_valid && cmd_ready) cmd_ff <= cmd;
      // registered memory reads
      if (rdo) rdq_ff <= dmem[raddr[DIDX_BITS-1:0]];
      rrd_ff <= rmem[rp_ff[RIDX_BITS-1:0] - RIDX_BITS'(1)];
      case (st_ff)
         ST_RD1: a_ff <= rdq_ff;
         ST_RD2: b_ff <= rdq_ff;
         ST_RD3: c_ff <= rdq_ff;
         default: ;
      endcase
      // product used is the one taken in EXEC, where rdq_ff holds the fourth cell
      prod_ff <= (cmd_ff.op == OP_MUL)
         ? dcell_type'($signed(b_ff) * $signed(a_ff))
         : dcell_type'({c_ff, rdq_ff} * b_ff);
      w0_ff <= w0_in; w1_ff <= w1_in; wa0_ff <= wa0_in; wa1_ff <= wa1_in;
      we0_ff <= we0_in; we1_ff <= we1_in;
      num_ff <= num_in; quo_ff <= quo_in; rem_ff <= rem_in; den_ff <= den_in;
      qneg_ff <= qneg_in; rneg_ff <= rneg_in; step_ff <= step_in;
      top_ff <= top_in; sec_ff <= sec_in;
      pick_sel_ff <= pick_sel_in; rpush_ff <= rpush_in; rpop_ff <= rpop_in;
   end

   // data memory port: two writes over WB1/OUT0 (one per cycle)
   always_ff @(posedge clock) begin
      if (st_ff == ST_WB1 && we1_ff) dmem[wa1_ff[DIDX_BITS-1:0]] <= w1_ff;
      else if (st_ff == ST_OUT0 && we0_ff) dmem[wa0_ff[DIDX_BITS-1:0]] <= w0_ff;
      if (rpush_ff) rmem[rp_ff[RIDX_BITS-1:0] - RIDX_BITS'(1)] <= a_ff;
   end

   // we flags must survive into OUT0
   // (held until the next IDLE)
   assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_DIV |-> err_ff == ERR_OK)
      else $error("divider run after error");
   assert property (@(posedge clock) disable iff (reset)
      dp_ff <= DPTR_BITS'(DATA_DEPTH))
      else $error("data pointer beyond depth");
   assert property (@(posedge clock) disable iff (reset)
      rp_ff <= RPTR_BITS'(RETURN_DEPTH))
      else $error("return pointer beyond depth");
   assert property (@(posedge clock) disable iff (reset)
      rpop_ff |-> $past(st_ff) == ST_WB0)
      else $error("return pop outside writeback");
endmodule

// ----- rtl/core/forth_stack_alu_core.sv -----
// Top level: Forth primitive stack ALU core.
// Executes one Forth primitive per request transaction and answers with one
// response transaction. An opcode that reports an error skips writeback;
// mul and uma pass through a multiply state, and div, mod and ummod through
// the one-bit-per-cycle restoring divider (2*CELL_BITS steps plus a sign fix).
// The sequencer takes the next command only once the response has been taken
// and its valid register has cleared. Data stack reads go through the single
// registered read port of the data stack memory; the return stack has its own
// registered read. A two-entry command queue sits between the front end and
// the sequencer, so requests are taken while one is executing.
module forth_stack_alu_core import fsac_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [23:0] req_tdata, // operation[4:0], literal[20:5]
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [55:0] rsp_tdata  // top_cell[15:0], second_cell[31:16],
                                  // data_count[37:32], return_count[43:38],
                                  // error_code[46:44]
);
   logic cmd_valid, cmd_ready;
   cmd_type cmd;

   fsac_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .cmd_valid, .cmd_ready, .cmd
   );

   fsac_back u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );
endmodule

// ----- verif/forth_stack_alu_core_tb.sv -----
// Testbench for the Forth stack ALU core: directed and random opcode streams.
`timescale 1ns / 100ps

module forth_stack_alu_core_tb;
   import fsac_pkg::*;

   // packed from the highest field down, matching rsp_tdata[46:0]
   typedef struct packed {
      logic [2:0]  err;
      logic [5:0]  rcount;
      logic [5:0]  dcount;
      logic [15:0] second;
      logic [15:0] top;
   } stack_view_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;   // operation[4:0], literal[20:5]
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;        // top, second, data_count, return_count, error_code

   forth_stack_alu_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic [15:0] dstk [DATA_DEPTH];
   logic [15:0] rstk [RETURN_DEPTH];
   int unsigned dptr, rptr;
   stack_view_type expected_views [$];
   int fail_count = 0;
   int burst_left = 0;

   // apply one primitive to the shadow stacks, queue the expected view
   function automatic void predict_step(logic [4:0] op, logic [15:0] lit);
      logic [15:0] a, b, c, e;
      logic [31:0] dbl, qm, rm, dm;
      logic [15:0] nm;
      logic [63:0] wide;
      logic [2:0] err;
      stack_view_type v;
      int unsigned dp;
      dp = dptr;
      err = ERR_OK;
      a = 0; b = 0; c = 0; e = 0;
      if (op > 5'd23) err = ERR_OPCODE;
      else if (dp < reads_needed(op)) err = ERR_UNDER;
      else begin
         if (dp >= 1) a = dstk[dp-1];
         if (dp >= 2) b = dstk[dp-2];
         if (dp >= 3) c = dstk[dp-3];
         if (dp >= 4) e = dstk[dp-4];
         if (op == OP_PICK && a >= dp - 1) err = ERR_UNDER;
         else if (op == OP_FROMR && rptr == 0) err = ERR_UNDER;
         else if ((op == OP_DIV || op == OP_MOD || op == OP_UMMOD) && a == 0) err = ERR_DIVZ;
         else if ((op == OP_LIT || op == OP_DUP || op == OP_FROMR || op == OP_DEPTH ||
                   op == OP_RDEPTH) && dp >= DATA_DEPTH) err = ERR_OVER;
         else if (op == OP_TOR && rptr >= RETURN_DEPTH) err = ERR_OVER;
      end
      if (err == ERR_OK) begin
         case (op)
            OP_LIT: begin dstk[dp] = lit; dp++; end
            OP_DROP: dp--;
            OP_DUP: begin dstk[dp] = a; dp++; end
            OP_SWAP: begin dstk[dp-1] = b; dstk[dp-2] = a; end
            OP_PICK: dstk[dp-1] = dstk[dp-2-a];
            OP_ADD: begin dstk[dp-2] = b + a; dp--; end
            OP_SUB: begin dstk[dp-2] = b - a; dp--; end
            OP_MUL: begin
               dbl = 32'($signed(b) * $signed(a));
               dstk[dp-2] = dbl[15:0]; dstk[dp-1] = dbl[31:16];
            end
            OP_DIV, OP_MOD: begin
               dbl = {b, c};
               dm = dbl[31] ? -dbl : dbl;
               nm = a[15] ? -a : a;
               qm = dm / nm; rm = dm % nm;
               if (dbl[31] != a[15]) qm = -qm;
               if (dbl[31]) rm = -rm;
               dstk[dp-3] = (op == OP_DIV) ? qm[15:0] : rm[15:0];
               dp -= 2;
            end
            OP_TOR: begin rstk[rptr] = a; rptr++; dp--; end
            OP_FROMR: begin rptr--; dstk[dp] = rstk[rptr]; dp++; end
            OP_EQ: begin dstk[dp-2] = (b == a) ? 16'hFFFF : 16'h0; dp--; end
            OP_LT: begin dstk[dp-2] = ($signed(b) < $signed(a)) ? 16'hFFFF : 16'h0; dp--; end
            OP_AND: begin dstk[dp-2] = b & a; dp--; end
            OP_OR: begin dstk[dp-2] = b | a; dp--; end
            OP_XOR: begin dstk[dp-2] = b ^ a; dp--; end
            OP_SHL: begin dstk[dp-2] = (a >= 16) ? 16'h0 : b << a; dp--; end
            OP_SHR: begin dstk[dp-2] = (a >= 16) ? 16'h0 : b >> a; dp--; end
            OP_DEPTH: begin dstk[dp] = 16'(dp); dp++; end
            OP_RDEPTH: begin dstk[dp] = 16'(rptr); dp++; end
            OP_UMA: begin
               wide = {32'h0, c, e} * {48'h0, b} + {48'h0, a};
               dstk[dp-4] = wide[15:0]; dstk[dp-3] = wide[31:16];
               dp -= 2;
            end
            OP_ULT: begin dstk[dp-2] = (b < a) ? 16'hFFFF : 16'h0; dp--; end
            default: begin
               dbl = {b, c};
               qm = dbl / a; rm = dbl % a;
               dstk[dp-3] = rm[15:0]; dstk[dp-2] = qm[15:0];
               dp--;
            end
         endcase
         dptr = dp;
      end
      v.top = (dptr >= 1) ? dstk[dptr-1] : 16'h0;
      v.second = (dptr >= 2) ? dstk[dptr-2] : 16'h0;
      v.dcount = 6'(dptr);
      v.rcount = 6'(rptr);
      v.err = err;
      expected_views.push_back(v);
   endfunction

   // send one transaction with bursty gaps
   task automatic send_op(logic [4:0] op, logic [15:0] lit);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {3'b0, lit, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_step(op, lit);
   endtask

   task automatic idle_req();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // receiver stall pattern: alternating calm and choppy stretches
   int stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (reset) rsp_tready <= 1'b0;
      else if ((stall_phase / 200) % 3 == 0) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   // response checker
   always @(posedge clock) begin
      stack_view_type got, exp_v;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[46:0];
         if (expected_views.size() == 0) begin
            $error("unexpected response %h", rsp_tdata);
            fail_count++;
         end else begin
            exp_v = expected_views.pop_front();
            if (got.top !== exp_v.top) begin
               $error("top_cell exp %h got %h", exp_v.top, got.top); fail_count++; end
            if (got.second !== exp_v.second) begin
               $error("second_cell exp %h got %h", exp_v.second, got.second); fail_count++; end
            if (got.dcount !== exp_v.dcount) begin
               $error("data_count exp %0d got %0d", exp_v.dcount, got.dcount); fail_count++; end
            if (got.rcount !== exp_v.rcount) begin
               $error("return_count exp %0d got %0d", exp_v.rcount, got.rcount);
               fail_count++;
            end
            if (got.err !== exp_v.err) begin
               $error("error_code exp %0d got %0d", exp_v.err, got.err); fail_count++; end
         end
      end
   end

   function automatic logic [15:0] rand_cell();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'hFFFF;
         3: return 16'(4'($urandom));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic push_lit(logic [15:0] v);
      send_op(OP_LIT, v);
   endtask

   // empty the data stack and the return stack
   task automatic drain_stacks();
      while (rptr > 0) begin
         if (dptr >= DATA_DEPTH) send_op(OP_DROP, 0);
         send_op(OP_FROMR, 0);
      end
      while (dptr > 0) send_op(OP_DROP, 0);
   endtask

   task automatic test_underflow_and_unknown();
      send_op(OP_DROP, 0);
      send_op(OP_FROMR, 0);
      send_op(OP_UMA, 0);
      send_op(5'd24, 16'h1234);
      send_op(5'd31, 16'hFFFF);
      send_op(OP_DEPTH, 0);
      send_op(OP_RDEPTH, 0);
      drain_stacks();
   endtask

   task automatic test_arith_extremes();
      push_lit(16'h7FFF); push_lit(16'h8000); send_op(OP_MUL, 0);
      push_lit(16'hFFFF); send_op(OP_DIV, 0);            // quotient wraps
      push_lit(16'h0000); push_lit(16'h0000); send_op(OP_MOD, 0);  // divide by zero
      send_op(OP_UMMOD, 0);
      push_lit(16'h0005); send_op(OP_UMMOD, 0);
      push_lit(16'h0003); push_lit(16'h0007); send_op(OP_UMA, 0);
      push_lit(16'h0010); send_op(OP_SHL, 0);
      push_lit(16'h000F); send_op(OP_SHR, 0);
      push_lit(16'h0009); send_op(OP_PICK, 0);             // index out of range
      push_lit(16'h0000); send_op(OP_PICK, 0);
      drain_stacks();
   endtask

   task automatic test_overflow();
      while (dptr < DATA_DEPTH) push_lit(rand_cell());
      send_op(OP_LIT, 16'h5555);
      send_op(OP_DUP, 0);
      send_op(OP_DEPTH, 0);
      send_op(OP_RDEPTH, 0);
      while (rptr < RETURN_DEPTH) send_op(OP_TOR, 0);
      push_lit(16'h1);
      send_op(OP_TOR, 0);                                 // return full
      send_op(OP_FROMR, 0);
      drain_stacks();
   endtask

   task automatic test_random(int count);
      logic [4:0] op;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 2) == 0 && dptr < DATA_DEPTH - 4) begin
            // push one to four random literals before the op is chosen
            repeat ($urandom_range(1, 4)) begin push_lit(rand_cell()); n++; end
         end
         if ($urandom_range(0, 40) == 0) op = 5'($urandom_range(24, 31));
         else op = 5'($urandom_range(0, 23));
         if (op == OP_PICK && dptr > 1 && $urandom_range(0, 3) != 0)
            push_lit(16'($urandom_range(0, dptr - 2)));
         if (op == OP_LIT) push_lit(rand_cell());
         else send_op(op, 16'($urandom));
         if (dptr > 24 && $urandom_range(0, 3) == 0) send_op(OP_DROP, 0);
      end
      drain_stacks();
   endtask

   initial begin
      for (int i = 0; i < DATA_DEPTH; i++) dstk[i] = 0;
      for (int i = 0; i < RETURN_DEPTH; i++) rstk[i] = 0;
      dptr = 0; rptr = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_underflow_and_unknown();
      test_arith_extremes();
      test_overflow();
      test_random(1750);
      idle_req();
      while (expected_views.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("tb: failure");
      $finish;
   end
endmodule
